// File: hw/rtl/ins_pkg.sv
// Package for the insertion sorter: transaction payload types and the
// command/status structs between controller and datapath. No dependencies.
package ins_pkg;

   localparam int ValueWidth = 32;

   // Input transaction: one element of a run.
   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic                         final_item;
   } req_payload_type;

   // Output transaction: one element of the sorted run.
   typedef struct packed {
      logic signed [ValueWidth-1:0] sorted_value;
      logic                         end_of_run;
      logic                         dropped;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;     // insert the input value into the cell row
      logic shift_out;  // move every cell down by one place
   } ins_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_entry; // exactly one entry is left in the row
   } ins_status_type;

endpackage

// File: hw/rtl/ins_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Depends on nothing; payload type is a parameter (see ins_pkg).
interface ins_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ins_ctrl.sv
// Controller state machine of the insertion sorter.
// Depends on ins_pkg for the command and status structs.
module ins_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final_item,
   input  logic                    rsp_ready,
   input  ins_pkg::ins_status_type status,
   output ins_pkg::ins_cmd_type    cmd,
   output logic                    req_ready,
   output logic                    rsp_valid
);
   import ins_pkg::*;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      rsp_fire;

   assign req_fire  = req_valid && req_ready_ff;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // Insert on every accepted input; shift out on every delivered result.
   assign cmd.insert    = req_fire;
   assign cmd.shift_out = rsp_fire;

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_COLLECT: begin
               if (req_fire && req_final_item) begin
                  state_ff     <= ST_EMIT;
                  req_ready_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (rsp_fire && status.last_entry) begin
                  state_ff     <= ST_COLLECT;
                  req_ready_ff <= 1'b1;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_COLLECT;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/ins_datapath.sv
// Datapath of the insertion sorter: a row of compare-and-shift cells,
// the fill count and the overflow flag. Depends on ins_pkg.
module ins_datapath #(
   parameter int MAX_ITEMS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ins_pkg::ins_cmd_type                  cmd,
   input  logic signed [ins_pkg::ValueWidth-1:0] in_value,
   output ins_pkg::ins_status_type               status,
   output ins_pkg::rsp_payload_type              out_payload,
   output logic                                  not_empty
);
   import ins_pkg::*;

   localparam int CountWidth = $clog2(MAX_ITEMS + 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(MAX_ITEMS);
   localparam logic [CountWidth-1:0] OneCount  = CountWidth'(1);

   logic signed [ValueWidth-1:0] cells_ff [MAX_ITEMS];
   logic signed [ValueWidth-1:0] cells_in [MAX_ITEMS];
   logic signed [ValueWidth-1:0] below_val [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]         gt;
   logic [MAX_ITEMS-1:0]         below_gt;
   logic [CountWidth-1:0]        fill_ff;
   logic [CountWidth-1:0]        fill_in;
   logic                         overflow_ff;
   logic                         overflow_in;
   logic                         full;

   assign full = (fill_ff == FullCount);

   // Each occupied cell compares its entry with the new value in parallel.
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         gt[i] = (CountWidth'(i) < fill_ff) && (cells_ff[i] > in_value);
      end
      below_gt[0]  = 1'b0;
      below_val[0] = in_value;
      for (int i = 1; i < MAX_ITEMS; i++) begin
         below_gt[i]  = gt[i-1];
         below_val[i] = cells_ff[i-1];
      end
   end

   // Next cell contents: insert shifts the greater suffix up by one place,
   // shift-out moves the whole row down towards cell zero.
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.shift_out) begin
            if (i < MAX_ITEMS - 1) begin
               cells_in[i] = cells_ff[(i + 1) % MAX_ITEMS];
            end
         end else if (cmd.insert && !full && CountWidth'(i) <= fill_ff) begin
            if ((CountWidth'(i) < fill_ff) && !gt[i]) begin
               cells_in[i] = cells_ff[i];
            end else if (below_gt[i]) begin
               cells_in[i] = below_val[i];
            end else begin
               cells_in[i] = in_value;
            end
         end
      end
   end

   // Fill count and overflow flag; both are back at zero after the last result.
   always_comb begin
      fill_in     = fill_ff;
      overflow_in = overflow_ff;
      if (cmd.shift_out) begin
         fill_in = fill_ff - OneCount;
         if (fill_ff == OneCount) begin
            overflow_in = 1'b0;
         end
      end else if (cmd.insert) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            fill_in = fill_ff + OneCount;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         overflow_ff <= overflow_in;
      end
   end

   // The cell row holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   assign status.last_entry        = (fill_ff == OneCount);
   assign out_payload.sorted_value = cells_ff[0];
   assign out_payload.end_of_run   = (fill_ff == OneCount);
   assign out_payload.dropped      = overflow_ff;
   assign not_empty                = (fill_ff != '0);

endmodule

// File: hw/rtl/insertion_sorter_core.sv
// Top level of the insertion sorter: joins controller and datapath.
// Depends on ins_pkg, ins_stream_if, ins_ctrl and ins_datapath.
//
// Usage: signed 32-bit values arrive as transactions on req_ch, one per
// element; the transaction with final_item set closes the run. Each value is
// inserted into an ascending row of MAX_ITEMS compare-and-shift cells in the
// cycle it is accepted, so a run is taken in at one element per cycle. Equal
// values keep their arrival order. Elements arriving with the row full are
// discarded and the dropped bit is set on every result of that run.
// After the final element, rsp_ch delivers the stored values in ascending
// order starting the next cycle, one per cycle while rsp_ch.ready is high;
// end_of_run marks the greatest one. During output req_ch.ready is low, and
// a stall on rsp_ch simply holds the current result and the row.
// After the last result the block is empty and takes a new run.
// Reset (synchronous, active high) empties the row and clears the flag.
module insertion_sorter_core #(
   parameter int MAX_ITEMS = 32
) (
   input logic clock,
   input logic reset,
   ins_stream_if.sink   req_ch,
   ins_stream_if.source rsp_ch
);
   import ins_pkg::*;

   ins_cmd_type     cmd;
   ins_status_type  status;
   rsp_payload_type out_payload;
   req_payload_type req_payload;
   logic            not_empty;

   assign req_payload = req_ch.payload;

   ins_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_final_item (req_payload.final_item),
      .rsp_ready      (rsp_ch.ready),
      .status         (status),
      .cmd            (cmd),
      .req_ready      (req_ch.ready),
      .rsp_valid      (rsp_ch.valid)
   );

   ins_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_value    (req_payload.value),
      .status      (status),
      .out_payload (out_payload),
      .not_empty   (not_empty)
   );

   assign rsp_ch.payload = out_payload;

   // A result is only offered while the row holds an entry.
   a_valid_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> not_empty)
      else $error("result offered from an empty row");

   // Input and output never stand open at the same time.
   a_phase_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input and output phases overlap");

   // The final element of a run starts the output phase.
   a_final_starts_emit: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_payload.final_item) |=> rsp_ch.valid)
      else $error("final element did not start output");

   // Delivering the end of run returns the block to taking input, empty.
   a_end_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && out_payload.end_of_run)
         |=> (req_ch.ready && !not_empty))
      else $error("block did not return empty after end of run");

endmodule

// File: tb/tb_insertion_sorter_core.sv
// Testbench for insertion_sorter_core: drives runs of signed values, predicts each
// sorted run and checks every result against it. Depends on ins_pkg, ins_stream_if
// and insertion_sorter_core.
module tb_insertion_sorter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ins_pkg::*;

   localparam int MaxItems = 32;
   localparam int QuietLimit = 2000;
   localparam int RandomItems = 160;
   localparam int DirectedRows = 11;
   localparam logic signed [ValueWidth-1:0] MinValue = 32'sh8000_0000;
   localparam logic signed [ValueWidth-1:0] MaxValue = 32'sh7fff_ffff;

   typedef enum int {MixWide, MixNarrow, MixCorner} value_mix_type;
   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_phase_type;

   // One row of directed stimulus: a value sent reps times (counting down), with the
   // final flag on the last one. Rows marked known carry their result typed in.
   typedef struct {
      logic signed [ValueWidth-1:0] value;
      int                           reps;
      logic                         last;
      logic                         known;
      rsp_payload_type              result;
   } directed_row_type;

   logic clock;
   logic reset;

   ins_stream_if #(.payload_type(req_payload_type)) req_ch ();
   ins_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   // Travels with the request payload: the typed-in result of a directed row.
   logic            req_known;
   rsp_payload_type req_known_result;

   // Predictor state and the results it has still to see.
   logic signed [ValueWidth-1:0] sorted_list[$];
   logic                         overflow_flag;
   rsp_payload_type              run_results[$];
   rsp_payload_type              expected_sorted_q[$];

   int unsigned      failures;
   int unsigned      quiet_cycles;
   int unsigned      send_idle_pct;
   int unsigned      rsp_stall_pct;
   directed_row_type directed_runs[DirectedRows];

   insertion_sorter_core #(
      .MAX_ITEMS(MaxItems)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Insert one value into the sorted list; on a final item, emit the whole list.
   task automatic sort_insert(input logic signed [ValueWidth-1:0] v, input logic last);
      int pos;
      run_results.delete();
      if (sorted_list.size() >= MaxItems) begin
         overflow_flag = 1'b1;
      end else begin
         pos = sorted_list.size();
         // Only strictly greater entries move up, so equal values keep arrival order.
         while (pos > 0 && sorted_list[pos-1] > v) pos--;
         sorted_list.insert(pos, v);
      end
      if (last) begin
         foreach (sorted_list[i]) begin
            run_results.push_back('{sorted_value: sorted_list[i],
                                    end_of_run: (i == sorted_list.size() - 1),
                                    dropped: overflow_flag});
         end
         sorted_list.delete();
         overflow_flag = 1'b0;
      end
   endtask

   // Compare one delivered result with the oldest expectation.
   task automatic check_sorted(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_sorted_q.size() == 0) begin
         $error("unexpected result: sorted_value=%0d end_of_run=%0b dropped=%0b",
                got.sorted_value, got.end_of_run, got.dropped);
         failures++;
      end else begin
         want = expected_sorted_q.pop_front();
         if (got.sorted_value !== want.sorted_value) begin
            $error("sorted_value mismatch: expected %0d, actual %0d",
                   want.sorted_value, got.sorted_value);
            failures++;
         end
         if (got.end_of_run !== want.end_of_run) begin
            $error("end_of_run mismatch: expected %0b, actual %0b",
                   want.end_of_run, got.end_of_run);
            failures++;
         end
         if (got.dropped !== want.dropped) begin
            $error("dropped mismatch: expected %0b, actual %0b", want.dropped, got.dropped);
            failures++;
         end
      end
   endtask

   // Monitor both channels, predict on each accepted request and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sort_insert(req_ch.payload.value, req_ch.payload.final_item);
            if (req_known) begin
               expected_sorted_q.push_back(req_known_result);
            end else begin
               foreach (run_results[i]) expected_sorted_q.push_back(run_results[i]);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) check_sorted(rsp_ch.payload);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side: stall at random according to the current phase.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Send one transaction, with random idle cycles ahead of it, and wait for it to go.
   task automatic send_item(input logic signed [ValueWidth-1:0] v, input logic last,
                            input logic known, input rsp_payload_type result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.payload.value      <= v;
      req_ch.payload.final_item <= last;
      req_known                 <= known;
      req_known_result          <= result;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold the request side quiet until every expected result has been delivered.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_sorted_q.size() != 0);
   endtask

   function automatic logic signed [ValueWidth-1:0] pick_value(input value_mix_type mix);
      logic signed [ValueWidth-1:0] v;
      case (mix)
         MixNarrow: v = int'($urandom_range(8)) - 4;
         MixCorner: begin
            case ($urandom_range(3))
               0: v = MinValue;
               1: v = MaxValue;
               2: v = '0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Stimulus: directed runs, then random runs under rotating idle phases.
   initial begin
      int unsigned     sent;
      int unsigned     run_len;
      int unsigned     run_idx;
      int unsigned     pick;
      value_mix_type   mix;
      idle_phase_type  phase;

      failures      = 0;
      quiet_cycles  = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      overflow_flag = 1'b0;
      reset                     <= 1'b1;
      req_ch.valid              <= 1'b0;
      req_ch.payload            <= '0;
      req_known                 <= 1'b0;
      req_known_result          <= '0;

      // Single-element runs at the extremes, at 0 and at -1; one run that opens with
      // mixed values and duplicates and overflows the store (the final item among the
      // discarded); and a check that the overflow flag is cleared afterwards.
      directed_runs = '{
         '{MinValue, 1, 1'b1, 1'b1, '{MinValue, 1'b1, 1'b0}},
         '{MaxValue, 1, 1'b1, 1'b1, '{MaxValue, 1'b1, 1'b0}},
         '{32'sd0,   1, 1'b1, 1'b1, '{32'sd0,   1'b1, 1'b0}},
         '{-32'sd1,  1, 1'b1, 1'b1, '{-32'sd1,  1'b1, 1'b0}},
         '{32'sd5,   1, 1'b0, 1'b0, '0},
         '{-32'sd3,  1, 1'b0, 1'b0, '0},
         '{MaxValue, 1, 1'b0, 1'b0, '0},
         '{32'sd5,   1, 1'b0, 1'b0, '0},
         '{MinValue, 1, 1'b0, 1'b0, '0},
         '{32'sd7,   MaxItems + 2, 1'b1, 1'b0, '0},
         '{32'sd42,  1, 1'b1, 1'b1, '{32'sd42,  1'b1, 1'b0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_runs[r]) begin
         for (int k = 0; k < directed_runs[r].reps; k++) begin
            send_item(directed_runs[r].value - k,
                      directed_runs[r].last && (k == directed_runs[r].reps - 1),
                      directed_runs[r].known, directed_runs[r].result);
         end
      end
      // The sender waits here until the directed runs have fully come out.
      drain_results();

      sent    = 0;
      run_idx = 0;
      while (sent < RandomItems) begin
         phase = idle_phase_type'(run_idx % 4);
         case (phase)
            IdleSender:   begin send_idle_pct = 68; rsp_stall_pct = 0;  end
            IdleReceiver: begin send_idle_pct = 0;  rsp_stall_pct = 68; end
            IdleBoth:     begin send_idle_pct = 13; rsp_stall_pct = 13; end
            default:      begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase

         // Mostly short runs, some long ones and a few that fill or overflow the store.
         pick = $urandom_range(19);
         if (pick < 17) run_len = $urandom_range(10, 1);
         else if (pick < 19) run_len = $urandom_range(MaxItems - 1, 11);
         else run_len = $urandom_range(MaxItems + 8, MaxItems);

         pick = $urandom_range(9);
         if (pick < 5) mix = MixWide;
         else if (pick < 8) mix = MixNarrow;
         else mix = MixCorner;

         for (int k = 0; k < run_len; k++) begin
            send_item(pick_value(mix), (k == run_len - 1), 1'b0, '0);
            sent++;
         end
         run_idx++;
      end

      drain_results();
      repeat (2 * MaxItems + 8) @(posedge clock);
      if (failures == 0 && expected_sorted_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ins_pkg.sv
hw/rtl/ins_stream_if.sv
hw/rtl/ins_ctrl.sv
hw/rtl/ins_datapath.sv
hw/rtl/insertion_sorter_core.sv
tb/tb_insertion_sorter_core.sv
